// ===== rtl/rv_dec_pkg.sv =====
// ----------------------------------------------------------------------------
// RV32IM instruction decoder package
// Shared opcodes, operation numbers and the decoded result record.
// ----------------------------------------------------------------------------
package rv_dec_pkg;

    localparam int InstrWidth = 32;
    localparam int OpWidth    = 6;
    localparam int RegWidth   = 6;
    localparam int ImmWidth   = 32;
    localparam int CsrWidth   = 12;

    // Register number that marks an unused register slot.
    localparam logic [RegWidth-1:0] NO_REG = 6'd32;

    // Major opcodes (word bits 6:0).
    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_AUIPC  = 7'h17;
    localparam logic [6:0] OPC_JAL    = 7'h6F;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [6:0] OPC_OPIMM  = 7'h13;
    localparam logic [6:0] OPC_OP     = 7'h33;
    localparam logic [6:0] OPC_FENCE  = 7'h0F;
    localparam logic [6:0] OPC_SYSTEM = 7'h73;

    // funct7 codes for register-register operations.
    localparam logic [6:0] F7_BASE = 7'b0000000;
    localparam logic [6:0] F7_ALT  = 7'b0100000;
    localparam logic [6:0] F7_MULDIV = 7'b0000001;

    // funct7 codes for the trap return instructions.
    localparam logic [6:0] F7_URET = 7'd0;
    localparam logic [6:0] F7_SRET = 7'd8;
    localparam logic [6:0] F7_MRET = 7'd24;

    // rs2 field codes for system instructions with funct3 zero.
    localparam logic [4:0] SYS_ECALL  = 5'd0;
    localparam logic [4:0] SYS_EBREAK = 5'd1;
    localparam logic [4:0] SYS_XRET   = 5'd2;
    localparam logic [4:0] SYS_WFI    = 5'd5;

    // Dense operation numbers in ISA manual order.
    localparam logic [OpWidth-1:0] OP_LUI    = 6'd0;
    localparam logic [OpWidth-1:0] OP_AUIPC  = 6'd1;
    localparam logic [OpWidth-1:0] OP_JAL    = 6'd2;
    localparam logic [OpWidth-1:0] OP_JALR   = 6'd3;
    localparam logic [OpWidth-1:0] OP_BEQ    = 6'd4;
    localparam logic [OpWidth-1:0] OP_BNE    = 6'd5;
    localparam logic [OpWidth-1:0] OP_BLT    = 6'd6;
    localparam logic [OpWidth-1:0] OP_BGE    = 6'd7;
    localparam logic [OpWidth-1:0] OP_BLTU   = 6'd8;
    localparam logic [OpWidth-1:0] OP_BGEU   = 6'd9;
    localparam logic [OpWidth-1:0] OP_LB     = 6'd10;
    localparam logic [OpWidth-1:0] OP_LH     = 6'd11;
    localparam logic [OpWidth-1:0] OP_LW     = 6'd12;
    localparam logic [OpWidth-1:0] OP_LBU    = 6'd13;
    localparam logic [OpWidth-1:0] OP_LHU    = 6'd14;
    localparam logic [OpWidth-1:0] OP_SB     = 6'd15;
    localparam logic [OpWidth-1:0] OP_SH     = 6'd16;
    localparam logic [OpWidth-1:0] OP_SW     = 6'd17;
    localparam logic [OpWidth-1:0] OP_ADDI   = 6'd18;
    localparam logic [OpWidth-1:0] OP_SLTI   = 6'd19;
    localparam logic [OpWidth-1:0] OP_SLTIU  = 6'd20;
    localparam logic [OpWidth-1:0] OP_XORI   = 6'd21;
    localparam logic [OpWidth-1:0] OP_ORI    = 6'd22;
    localparam logic [OpWidth-1:0] OP_ANDI   = 6'd23;
    localparam logic [OpWidth-1:0] OP_SLLI   = 6'd24;
    localparam logic [OpWidth-1:0] OP_SRLI   = 6'd25;
    localparam logic [OpWidth-1:0] OP_SRAI   = 6'd26;
    localparam logic [OpWidth-1:0] OP_ADD    = 6'd27;
    localparam logic [OpWidth-1:0] OP_SUB    = 6'd28;
    localparam logic [OpWidth-1:0] OP_SLL    = 6'd29;
    localparam logic [OpWidth-1:0] OP_SLT    = 6'd30;
    localparam logic [OpWidth-1:0] OP_SLTU   = 6'd31;
    localparam logic [OpWidth-1:0] OP_XOR    = 6'd32;
    localparam logic [OpWidth-1:0] OP_SRL    = 6'd33;
    localparam logic [OpWidth-1:0] OP_SRA    = 6'd34;
    localparam logic [OpWidth-1:0] OP_OR     = 6'd35;
    localparam logic [OpWidth-1:0] OP_AND    = 6'd36;
    localparam logic [OpWidth-1:0] OP_FENCE  = 6'd37;
    localparam logic [OpWidth-1:0] OP_FENCEI = 6'd38;
    localparam logic [OpWidth-1:0] OP_ECALL  = 6'd39;
    localparam logic [OpWidth-1:0] OP_EBREAK = 6'd40;
    localparam logic [OpWidth-1:0] OP_CSRRW  = 6'd41;
    localparam logic [OpWidth-1:0] OP_CSRRS  = 6'd42;
    localparam logic [OpWidth-1:0] OP_CSRRC  = 6'd43;
    localparam logic [OpWidth-1:0] OP_CSRRWI = 6'd44;
    localparam logic [OpWidth-1:0] OP_CSRRSI = 6'd45;
    localparam logic [OpWidth-1:0] OP_CSRRCI = 6'd46;
    localparam logic [OpWidth-1:0] OP_URET   = 6'd47;
    localparam logic [OpWidth-1:0] OP_SRET   = 6'd48;
    localparam logic [OpWidth-1:0] OP_MRET   = 6'd49;
    localparam logic [OpWidth-1:0] OP_WFI    = 6'd50;
    localparam logic [OpWidth-1:0] OP_MUL    = 6'd51;
    localparam logic [OpWidth-1:0] OP_MULH   = 6'd52;
    localparam logic [OpWidth-1:0] OP_MULHSU = 6'd53;
    localparam logic [OpWidth-1:0] OP_MULHU  = 6'd54;
    localparam logic [OpWidth-1:0] OP_DIV    = 6'd55;
    localparam logic [OpWidth-1:0] OP_DIVU   = 6'd56;
    localparam logic [OpWidth-1:0] OP_REM    = 6'd57;
    localparam logic [OpWidth-1:0] OP_REMU   = 6'd58;

    // Decoded result of one instruction word.
    typedef struct packed {
        logic                 status;
        logic [OpWidth-1:0]   operation;
        logic [RegWidth-1:0]  dest_reg;
        logic [RegWidth-1:0]  src1_reg;
        logic [RegWidth-1:0]  src2_reg;
        logic [ImmWidth-1:0]  imm_value;
        logic [CsrWidth-1:0]  csr_addr;
    } dec_result_t;

endpackage

// ===== rtl/rv32im_instruction_decoder.sv =====
// ----------------------------------------------------------------------------
// RV32IM instruction decoder, streaming top level
// Registered decode of RV32I, M, fence, CSR and system instruction words.
// ----------------------------------------------------------------------------
// One instruction word enters on the slave stream and one decoded record leaves
// on the master stream for every word, in order. The block takes a new word in
// every cycle as long as the result side keeps up; an accepted input transaction
// passes through the input register and then the result register before its
// result is presented, with the decode logic in between.
// When the result side stalls, the block keeps accepting until both registers
// are full, and s_tready then follows m_tready. m_tuser carries the status flag
// (high for an encoding that is not supported, in which case m_tdata is all
// zero). Register numbers of 32 mean the slot is unused.
module rv32im_instruction_decoder
    import rv_dec_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // [31:0] instr_word

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,    // [5:0] operation, [11:6] dest_reg,
                                    // [17:12] src1_reg, [23:18] src2_reg,
                                    // [55:24] imm_value, [67:56] csr_addr,
                                    // [71:68] zero
    output logic        m_tuser     // [0] status
);

    logic [InstrWidth-1:0] instr_reg;
    logic                  in_valid_reg;
    dec_result_t           result_reg;
    logic                  out_valid_reg;
    dec_result_t           dec_result;
    logic                  out_advance;
    logic                  in_accept;

    // The result register can load when it is empty or being drained this cycle;
    // the input register can load when it is empty or passing its word onward.
    assign out_advance = !out_valid_reg || m_tready;
    assign s_tready    = !in_valid_reg || out_advance;
    assign in_accept   = s_tvalid && s_tready;

    rv_dec_core u_core (
        .instr_word (instr_reg),
        .result     (dec_result)
    );

    // Valid flags of the two register stages.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (out_advance) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    // Payload registers need no reset; they only load with a valid transaction.
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            instr_reg <= s_tdata;
        end
        if (out_advance && in_valid_reg) begin
            result_reg <= dec_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = result_reg.status;
    assign m_tdata  = {4'd0,
                       result_reg.csr_addr,
                       result_reg.imm_value,
                       result_reg.src2_reg,
                       result_reg.src1_reg,
                       result_reg.dest_reg,
                       result_reg.operation};

`ifndef SYNTHESIS
    // An invalid word presents an all-zero record.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata == 72'd0))
        else $error("invalid instruction with nonzero result fields");

    // A decoded word in the input stage reaches the result register when it moves.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_advance) |=> out_valid_reg)
        else $error("decoded transaction lost between stages");

    // Operation numbers stay within the defined range.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[5:0] <= OP_REMU))
        else $error("operation number out of range");

    // Only CSR instructions carry a CSR address.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[67:56] != 12'd0)) |->
            ((m_tdata[5:0] >= OP_CSRRW) && (m_tdata[5:0] <= OP_CSRRCI)))
        else $error("CSR address on a non-CSR operation");

    // Register numbers never exceed the no-register code.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata[11:6] <= NO_REG) && (m_tdata[17:12] <= NO_REG)
                      && (m_tdata[23:18] <= NO_REG)))
        else $error("register number out of range");
`endif

endmodule

// ===== rtl/rv_dec_core.sv =====
// ----------------------------------------------------------------------------
// RV32IM instruction decode logic
// Combinational decode of one instruction word into a dec_result_t record.
// ----------------------------------------------------------------------------
module rv_dec_core
    import rv_dec_pkg::*;
(
    input  logic [InstrWidth-1:0] instr_word,
    output dec_result_t           result
);

    logic [6:0]          opc;
    logic [2:0]          f3;
    logic [6:0]          f7;
    logic [4:0]          rd;
    logic [4:0]          rs1;
    logic [4:0]          rs2;
    logic [ImmWidth-1:0] imm_i;
    logic [ImmWidth-1:0] imm_s;
    logic [ImmWidth-1:0] imm_b;
    logic [ImmWidth-1:0] imm_u;
    logic [ImmWidth-1:0] imm_j;
    logic                known;
    dec_result_t         dec;

    assign opc = instr_word[6:0];
    assign f3  = instr_word[14:12];
    assign f7  = instr_word[31:25];
    assign rd  = instr_word[11:7];
    assign rs1 = instr_word[19:15];
    assign rs2 = instr_word[24:20];

    assign imm_i = {{20{instr_word[31]}}, instr_word[31:20]};
    assign imm_s = {{20{instr_word[31]}}, instr_word[31:25], instr_word[11:7]};
    assign imm_b = {{19{instr_word[31]}}, instr_word[31], instr_word[7],
                    instr_word[30:25], instr_word[11:8], 1'b0};
    assign imm_u = {12'd0, instr_word[31:12]};
    assign imm_j = {{11{instr_word[31]}}, instr_word[31], instr_word[19:12],
                    instr_word[20], instr_word[30:21], 1'b0};

    always_comb begin
        known         = 1'b0;
        dec           = '0;
        dec.dest_reg  = NO_REG;
        dec.src1_reg  = NO_REG;
        dec.src2_reg  = NO_REG;

        unique case (opc)
            OPC_LUI, OPC_AUIPC: begin
                known         = 1'b1;
                dec.operation = (opc == OPC_LUI) ? OP_LUI : OP_AUIPC;
                dec.dest_reg  = {1'b0, rd};
                dec.imm_value = imm_u;
            end
            OPC_JAL: begin
                known         = 1'b1;
                dec.operation = OP_JAL;
                dec.dest_reg  = {1'b0, rd};
                dec.imm_value = imm_j;
            end
            OPC_JALR, OPC_LOAD, OPC_OPIMM, OPC_FENCE: begin
                dec.dest_reg  = {1'b0, rd};
                dec.src1_reg  = {1'b0, rs1};
                dec.imm_value = imm_i;
                if (opc == OPC_JALR) begin
                    known         = (f3 == 3'd0);
                    dec.operation = OP_JALR;
                end else if (opc == OPC_FENCE) begin
                    known         = (f3 == 3'd0) || (f3 == 3'd1);
                    dec.operation = (f3 == 3'd0) ? OP_FENCE : OP_FENCEI;
                end else if (opc == OPC_LOAD) begin
                    known = 1'b1;
                    unique case (f3)
                        3'd0: dec.operation = OP_LB;
                        3'd1: dec.operation = OP_LH;
                        3'd2: dec.operation = OP_LW;
                        3'd4: dec.operation = OP_LBU;
                        3'd5: dec.operation = OP_LHU;
                        default: known = 1'b0;
                    endcase
                end else begin
                    known = 1'b1;
                    // Right shifts pick arithmetic or logical by word bit 30 only.
                    unique case (f3)
                        3'd0: dec.operation = OP_ADDI;
                        3'd1: dec.operation = OP_SLLI;
                        3'd2: dec.operation = OP_SLTI;
                        3'd3: dec.operation = OP_SLTIU;
                        3'd4: dec.operation = OP_XORI;
                        3'd5: dec.operation = instr_word[30] ? OP_SRAI : OP_SRLI;
                        3'd6: dec.operation = OP_ORI;
                        default: dec.operation = OP_ANDI;
                    endcase
                end
            end
            OPC_BRANCH: begin
                known         = 1'b1;
                dec.src1_reg  = {1'b0, rs1};
                dec.src2_reg  = {1'b0, rs2};
                dec.imm_value = imm_b;
                unique case (f3)
                    3'd0: dec.operation = OP_BEQ;
                    3'd1: dec.operation = OP_BNE;
                    3'd4: dec.operation = OP_BLT;
                    3'd5: dec.operation = OP_BGE;
                    3'd6: dec.operation = OP_BLTU;
                    3'd7: dec.operation = OP_BGEU;
                    default: known = 1'b0;
                endcase
            end
            OPC_STORE: begin
                known         = 1'b1;
                dec.src1_reg  = {1'b0, rs1};
                dec.src2_reg  = {1'b0, rs2};
                dec.imm_value = imm_s;
                unique case (f3)
                    3'd0: dec.operation = OP_SB;
                    3'd1: dec.operation = OP_SH;
                    3'd2: dec.operation = OP_SW;
                    default: known = 1'b0;
                endcase
            end
            OPC_OP: begin
                known        = 1'b1;
                dec.dest_reg = {1'b0, rd};
                dec.src1_reg = {1'b0, rs1};
                dec.src2_reg = {1'b0, rs2};
                if (f7 == F7_BASE) begin
                    unique case (f3)
                        3'd0: dec.operation = OP_ADD;
                        3'd1: dec.operation = OP_SLL;
                        3'd2: dec.operation = OP_SLT;
                        3'd3: dec.operation = OP_SLTU;
                        3'd4: dec.operation = OP_XOR;
                        3'd5: dec.operation = OP_SRL;
                        3'd6: dec.operation = OP_OR;
                        default: dec.operation = OP_AND;
                    endcase
                end else if (f7 == F7_ALT) begin
                    if (f3 == 3'd0) begin
                        dec.operation = OP_SUB;
                    end else if (f3 == 3'd5) begin
                        dec.operation = OP_SRA;
                    end else begin
                        known = 1'b0;
                    end
                end else if (f7 == F7_MULDIV) begin
                    unique case (f3)
                        3'd0: dec.operation = OP_MUL;
                        3'd1: dec.operation = OP_MULH;
                        3'd2: dec.operation = OP_MULHSU;
                        3'd3: dec.operation = OP_MULHU;
                        3'd4: dec.operation = OP_DIV;
                        3'd5: dec.operation = OP_DIVU;
                        3'd6: dec.operation = OP_REM;
                        default: dec.operation = OP_REMU;
                    endcase
                end else begin
                    known = 1'b0;
                end
            end
            OPC_SYSTEM: begin
                if (f3 == 3'd0) begin
                    known = 1'b1;
                    unique case (rs2)
                        SYS_ECALL:  dec.operation = OP_ECALL;
                        SYS_EBREAK: dec.operation = OP_EBREAK;
                        SYS_WFI:    dec.operation = OP_WFI;
                        SYS_XRET: begin
                            unique case (f7)
                                F7_URET: dec.operation = OP_URET;
                                F7_SRET: dec.operation = OP_SRET;
                                F7_MRET: dec.operation = OP_MRET;
                                default: known = 1'b0;
                            endcase
                        end
                        default: known = 1'b0;
                    endcase
                end else begin
                    known        = 1'b1;
                    dec.dest_reg = {1'b0, rd};
                    dec.csr_addr = instr_word[31:20];
                    // The immediate forms carry a zero-extended zimm in rs1.
                    if (f3[2]) begin
                        dec.imm_value = {27'd0, rs1};
                    end else begin
                        dec.src1_reg = {1'b0, rs1};
                    end
                    unique case (f3)
                        3'd1: dec.operation = OP_CSRRW;
                        3'd2: dec.operation = OP_CSRRS;
                        3'd3: dec.operation = OP_CSRRC;
                        3'd5: dec.operation = OP_CSRRWI;
                        3'd6: dec.operation = OP_CSRRSI;
                        3'd7: dec.operation = OP_CSRRCI;
                        default: known = 1'b0;
                    endcase
                end
            end
            default: known = 1'b0;
        endcase

        // An unknown encoding reports invalid with every other field zero.
        if (known) begin
            result = dec;
        end else begin
            result        = '0;
            result.status = 1'b1;
        end
    end

endmodule

// ===== tb/sv/rv32im_instruction_decoder_test.sv =====
// ----------------------------------------------------------------------------
// RV32IM instruction decoder testbench
// Streams instruction words through the decoder with random idle cycles on
// both sides and compares each decoded record with a local decode of the word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rv32im_instruction_decoder_test;

    import rv_dec_pkg::*;

    localparam int RANDOM_WORDS = 1800;
    localparam int STUCK_LIMIT  = 1000;
    localparam int PRINT_LIMIT  = 40;

    // Marks a funct3 slot that has no encoding.
    localparam logic [5:0] NO_OP = 6'h3F;

    // Operation numbers indexed by funct3, slot 7 in the top bits.
    localparam logic [47:0] JALR_OPS   = {{7{NO_OP}}, OP_JALR};
    localparam logic [47:0] BRANCH_OPS = {OP_BGEU, OP_BLTU, OP_BGE, OP_BLT,
                                          NO_OP, NO_OP, OP_BNE, OP_BEQ};
    localparam logic [47:0] LOAD_OPS   = {NO_OP, NO_OP, OP_LHU, OP_LBU,
                                          NO_OP, OP_LW, OP_LH, OP_LB};
    localparam logic [47:0] STORE_OPS  = {{5{NO_OP}}, OP_SW, OP_SH, OP_SB};
    localparam logic [47:0] OPIMM_OPS  = {OP_ANDI, OP_ORI, OP_SRLI, OP_XORI,
                                          OP_SLTIU, OP_SLTI, OP_SLLI, OP_ADDI};
    localparam logic [47:0] BASE_OPS   = {OP_AND, OP_OR, OP_SRL, OP_XOR,
                                          OP_SLTU, OP_SLT, OP_SLL, OP_ADD};
    localparam logic [47:0] ALT_OPS    = {{2{NO_OP}}, OP_SRA, {4{NO_OP}}, OP_SUB};
    localparam logic [47:0] MULDIV_OPS = {OP_REMU, OP_REM, OP_DIVU, OP_DIV,
                                          OP_MULHU, OP_MULHSU, OP_MULH, OP_MUL};
    localparam logic [47:0] FENCE_OPS  = {{6{NO_OP}}, OP_FENCEI, OP_FENCE};
    localparam logic [47:0] CSR_OPS    = {OP_CSRRCI, OP_CSRRSI, OP_CSRRWI, NO_OP,
                                          OP_CSRRC, OP_CSRRS, OP_CSRRW, NO_OP};
    localparam logic [47:0] NONE_OPS   = {8{NO_OP}};

    localparam logic [76:0] KNOWN_OPCODES = {OPC_LUI, OPC_AUIPC, OPC_JAL, OPC_JALR,
                                             OPC_BRANCH, OPC_LOAD, OPC_STORE,
                                             OPC_OPIMM, OPC_OP, OPC_FENCE, OPC_SYSTEM};

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;
    logic        m_tuser;

    // Words waiting to be sent, and the words and decodes of accepted transactions
    // whose results have not come back yet.
    logic [31:0] instr_backlog[$];
    logic [31:0] inflight_words[$];
    dec_result_t inflight_decodes[$];

    int          mismatch_count = 0;
    int          send_hold = 0;
    int          recv_hold = 0;
    int unsigned cycle_count = 0;
    int unsigned stuck_cycles = 0;
    logic        calm_phase;

    rv32im_instruction_decoder dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // A quarter of the time, while cycle_count bits 9:8 are zero, runs with no idling on either side.
    assign calm_phase = (cycle_count[9:8] == 2'b00);

    // Selects the funct3-indexed operation table for a major opcode.
    function automatic logic [47:0] ops_by_funct3(input logic [6:0] opc, input logic [6:0] f7);
        case (opc)
            OPC_JALR:   return JALR_OPS;
            OPC_BRANCH: return BRANCH_OPS;
            OPC_LOAD:   return LOAD_OPS;
            OPC_STORE:  return STORE_OPS;
            OPC_OPIMM:  return OPIMM_OPS;
            OPC_FENCE:  return FENCE_OPS;
            OPC_SYSTEM: return CSR_OPS;
            OPC_OP: begin
                if (f7 == F7_BASE) return BASE_OPS;
                else if (f7 == F7_ALT) return ALT_OPS;
                else if (f7 == F7_MULDIV) return MULDIV_OPS;
                else return NONE_OPS;
            end
            default:    return NONE_OPS;
        endcase
    endfunction

    // Expected decode of one instruction word.
    function automatic dec_result_t decode_instr(input logic [31:0] w);
        dec_result_t r;
        logic [47:0] tbl;
        logic [6:0]  opc;
        logic [2:0]  f3;
        logic [5:0]  sel;
        opc = w[6:0];
        f3  = w[14:12];
        tbl = ops_by_funct3(opc, w[31:25]);
        sel = tbl[f3*6 +: 6];
        r = '0;
        r.dest_reg = NO_REG;
        r.src1_reg = NO_REG;
        r.src2_reg = NO_REG;
        case (opc)
            OPC_LUI, OPC_AUIPC: begin
                sel = (opc == OPC_LUI) ? OP_LUI : OP_AUIPC;
                r.dest_reg  = {1'b0, w[11:7]};
                r.imm_value = {12'd0, w[31:12]};
            end
            OPC_JAL: begin
                sel = OP_JAL;
                r.dest_reg  = {1'b0, w[11:7]};
                r.imm_value = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
            end
            OPC_JALR, OPC_LOAD, OPC_OPIMM, OPC_FENCE: begin
                // Word bit 30 alone turns a right shift immediate into SRAI.
                if (opc == OPC_OPIMM && sel == OP_SRLI && w[30]) sel = OP_SRAI;
                r.dest_reg  = {1'b0, w[11:7]};
                r.src1_reg  = {1'b0, w[19:15]};
                r.imm_value = {{20{w[31]}}, w[31:20]};
            end
            OPC_BRANCH: begin
                r.src1_reg  = {1'b0, w[19:15]};
                r.src2_reg  = {1'b0, w[24:20]};
                r.imm_value = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
            end
            OPC_STORE: begin
                r.src1_reg  = {1'b0, w[19:15]};
                r.src2_reg  = {1'b0, w[24:20]};
                r.imm_value = {{20{w[31]}}, w[31:25], w[11:7]};
            end
            OPC_OP: begin
                r.dest_reg = {1'b0, w[11:7]};
                r.src1_reg = {1'b0, w[19:15]};
                r.src2_reg = {1'b0, w[24:20]};
            end
            OPC_SYSTEM: begin
                if (f3 == '0) begin
                    // The rs2 field picks the system instruction; no registers.
                    case (w[24:20])
                        SYS_ECALL:  sel = OP_ECALL;
                        SYS_EBREAK: sel = OP_EBREAK;
                        SYS_WFI:    sel = OP_WFI;
                        SYS_XRET: begin
                            if (w[31:25] == F7_URET) sel = OP_URET;
                            else if (w[31:25] == F7_SRET) sel = OP_SRET;
                            else if (w[31:25] == F7_MRET) sel = OP_MRET;
                            else sel = NO_OP;
                        end
                        default:    sel = NO_OP;
                    endcase
                end else begin
                    r.dest_reg = {1'b0, w[11:7]};
                    r.csr_addr = w[31:20];
                    if (f3[2]) r.imm_value = {27'd0, w[19:15]};
                    else r.src1_reg = {1'b0, w[19:15]};
                end
            end
            default: sel = NO_OP;
        endcase
        if (sel == NO_OP) begin
            r = '0;
            r.status = 1'b1;
        end else begin
            r.operation = sel;
        end
        return r;
    endfunction

    function automatic logic [2:0] funct3_of(input logic [47:0] tbl, input logic [5:0] op);
        for (int i = 0; i < 8; i++) begin
            if (tbl[i*6 +: 6] == op) return i[2:0];
        end
        return '0;
    endfunction

    // Builds a well-formed word for the given operation with random contents.
    function automatic logic [31:0] encode_instr(input logic [5:0] op);
        logic [31:0] w;
        logic [6:0]  opc;
        w = $urandom;
        if (op == OP_LUI) opc = OPC_LUI;
        else if (op == OP_AUIPC) opc = OPC_AUIPC;
        else if (op == OP_JAL) opc = OPC_JAL;
        else if (op == OP_JALR) opc = OPC_JALR;
        else if (op <= OP_BGEU) opc = OPC_BRANCH;
        else if (op <= OP_LHU) opc = OPC_LOAD;
        else if (op <= OP_SW) opc = OPC_STORE;
        else if (op <= OP_SRAI) opc = OPC_OPIMM;
        else if (op <= OP_AND || op >= OP_MUL) opc = OPC_OP;
        else if (op <= OP_FENCEI) opc = OPC_FENCE;
        else opc = OPC_SYSTEM;
        w[6:0] = opc;
        if (opc == OPC_OP) begin
            if (op == OP_SUB || op == OP_SRA) w[31:25] = F7_ALT;
            else if (op >= OP_MUL) w[31:25] = F7_MULDIV;
            else w[31:25] = F7_BASE;
        end
        if (op == OP_ECALL || op == OP_EBREAK || op == OP_WFI ||
            (op >= OP_URET && op <= OP_MRET)) begin
            w[14:12] = '0;
            case (op)
                OP_ECALL:  w[24:20] = SYS_ECALL;
                OP_EBREAK: w[24:20] = SYS_EBREAK;
                OP_WFI:    w[24:20] = SYS_WFI;
                OP_URET:   w[31:20] = {F7_URET, SYS_XRET};
                OP_SRET:   w[31:20] = {F7_SRET, SYS_XRET};
                default:   w[31:20] = {F7_MRET, SYS_XRET};
            endcase
        end else if (op == OP_SRAI) begin
            w[14:12] = funct3_of(OPIMM_OPS, OP_SRLI);
            w[30] = 1'b1;
        end else if (op > OP_JAL) begin
            w[14:12] = funct3_of(ops_by_funct3(opc, w[31:25]), op);
            if (op == OP_SRLI) w[30] = 1'b0;
        end
        return w;
    endfunction

    // Mostly short idle stretches, now and then a long one.
    function automatic int idle_len();
        if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
        return $urandom_range(6, 25);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] word,
                                   input logic [31:0] got, input logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("[%0t] word 0x%08h: %s got 0x%0h, expected 0x%0h",
                     $time, word, what, got, want);
    endtask

    task automatic check_field(input string what, input logic [31:0] word,
                               input logic [31:0] got, input logic [31:0] want);
        if (got !== want) report_mismatch(what, word, got, want);
    endtask

    // Input side: records every accepted word with its expected decode, then
    // offers the next word from the backlog unless an idle stretch is running.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid  <= 1'b0;
            send_hold <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                inflight_words.push_back(s_tdata);
                inflight_decodes.push_back(decode_instr(s_tdata));
            end
            if (!s_tvalid || s_tready) begin
                if (send_hold != 0 || instr_backlog.size() == 0) begin
                    s_tvalid <= 1'b0;
                    s_tdata  <= $urandom;
                    if (send_hold != 0) send_hold <= send_hold - 1;
                end else begin
                    s_tvalid  <= 1'b1;
                    s_tdata   <= instr_backlog.pop_front();
                    send_hold <= (calm_phase || $urandom_range(0, 99) >= 30) ? 0 : idle_len();
                end
            end
        end
    end

    // Result side: checks each accepted record against the oldest expected
    // decode and throttles m_tready.
    always @(posedge aclk) begin : result_check
        dec_result_t want;
        logic [31:0] word;
        if (!aresetn) begin
            m_tready  <= 1'b0;
            recv_hold <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (inflight_decodes.size() == 0) begin
                    report_mismatch("unexpected result, tdata[31:0]", '0, m_tdata[31:0], '0);
                end else begin
                    want = inflight_decodes.pop_front();
                    word = inflight_words.pop_front();
                    check_field("status", word, 32'(m_tuser), 32'(want.status));
                    check_field("operation", word, 32'(m_tdata[5:0]), 32'(want.operation));
                    check_field("dest_reg", word, 32'(m_tdata[11:6]), 32'(want.dest_reg));
                    check_field("src1_reg", word, 32'(m_tdata[17:12]), 32'(want.src1_reg));
                    check_field("src2_reg", word, 32'(m_tdata[23:18]), 32'(want.src2_reg));
                    check_field("imm_value", word, m_tdata[55:24], want.imm_value);
                    check_field("csr_addr", word, 32'(m_tdata[67:56]), 32'(want.csr_addr));
                    check_field("pad bits", word, 32'(m_tdata[71:68]), '0);
                end
            end
            if (recv_hold != 0) begin
                m_tready  <= 1'b0;
                recv_hold <= recv_hold - 1;
            end else if (!calm_phase && $urandom_range(0, 99) < 25) begin
                m_tready  <= 1'b0;
                recv_hold <= idle_len() - 1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Counts cycles in which no transaction completes on either side.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stuck_cycles <= 0;
        else stuck_cycles <= stuck_cycles + 1;
    end

    initial begin
        wait (stuck_cycles >= STUCK_LIMIT);
        $display("** rv32im_instruction_decoder: FAILED **");
        $finish;
    end

    initial begin : stimulus
        logic [31:0] w;
        int          pick;

        // Directed words: field extremes, encoding holes and the special
        // decode rules. The funct3 values below land in unused table slots.
        instr_backlog.push_back(32'h0000_0000);
        instr_backlog.push_back(32'hFFFF_FFFF);
        w = encode_instr(OP_LUI);    w[31:7] = '1;                 instr_backlog.push_back(w);
        w = encode_instr(OP_AUIPC);  w[31:7] = '0;                 instr_backlog.push_back(w);
        w = encode_instr(OP_JAL);    w[31:7] = {1'b1, 24'd0};      instr_backlog.push_back(w);
        w = encode_instr(OP_JAL);    w[31:7] = {1'b0, {24{1'b1}}}; instr_backlog.push_back(w);
        w = encode_instr(OP_ADDI);   w[31:7] = {12'h800, 13'd0};   instr_backlog.push_back(w);
        w = encode_instr(OP_ADDI);   w[31:7] = {12'h7FF, {13{1'b1}}};
        instr_backlog.push_back(w);
        // Shift immediates with the unchecked funct7 bits set.
        w = encode_instr(OP_SRAI);   w[31:25] = '1;                instr_backlog.push_back(w);
        w = encode_instr(OP_SRLI);   w[31:25] = 7'b1011111;        instr_backlog.push_back(w);
        // Register ops with a funct7 that does not fit the funct3.
        w = encode_instr(OP_SLL);    w[31:25] = F7_ALT;            instr_backlog.push_back(w);
        w = encode_instr(OP_ADD);    w[31:25] = 7'b0000010;        instr_backlog.push_back(w);
        w = encode_instr(OP_BGEU);   w[31:25] = '1; w[11:7] = '1;  instr_backlog.push_back(w);
        w = encode_instr(OP_BEQ);    w[31:25] = 7'b1000000; w[11:7] = '0;
        instr_backlog.push_back(w);
        w = encode_instr(OP_BEQ);    w[14:12] = 3'd2;              instr_backlog.push_back(w);
        w = encode_instr(OP_SW);     w[31:25] = 7'b1000000; w[11:7] = '0;
        instr_backlog.push_back(w);
        w = encode_instr(OP_SW);     w[14:12] = 3'd3;              instr_backlog.push_back(w);
        w = encode_instr(OP_LW);     w[14:12] = 3'd3;              instr_backlog.push_back(w);
        w = encode_instr(OP_FENCEI);                               instr_backlog.push_back(w);
        w = encode_instr(OP_FENCE);  w[14:12] = 3'd2;              instr_backlog.push_back(w);
        w = encode_instr(OP_JALR);   w[14:12] = 3'd7;              instr_backlog.push_back(w);
        w = encode_instr(OP_WFI);                                  instr_backlog.push_back(w);
        w = encode_instr(OP_MRET);                                 instr_backlog.push_back(w);
        // Trap return with a funct7 that names no privilege level.
        w = encode_instr(OP_SRET);   w[25] = 1'b1;                 instr_backlog.push_back(w);
        w = encode_instr(OP_ECALL);  w[24:20] = 5'd3;              instr_backlog.push_back(w);
        w = encode_instr(OP_CSRRW);  w[31:20] = '1;                instr_backlog.push_back(w);
        w = encode_instr(OP_CSRRCI); w[19:15] = '1;                instr_backlog.push_back(w);
        w = encode_instr(OP_CSRRWI); w[12] = 1'b0;                 instr_backlog.push_back(w);

        // Random part: mostly well-formed words of every operation, mixed with
        // known opcodes with random remaining bits and with raw noise.
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                w = encode_instr(6'($urandom_range(0, OP_REMU)));
            end else if (pick < 88) begin
                w = $urandom;
                w[6:0] = KNOWN_OPCODES[$urandom_range(0, 10)*7 +: 7];
                // Steer system words toward the small rs2 and funct7 codes.
                if (w[6:0] == OPC_SYSTEM && $urandom_range(0, 1) == 1) begin
                    w[14:12] = '0;
                    w[24:23] = '0;
                    w[31:30] = '0;
                end
            end else begin
                w = $urandom;
            end
            instr_backlog.push_back(w);
        end

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        do @(negedge aclk);
        while (instr_backlog.size() != 0 || s_tvalid || inflight_decodes.size() != 0);
        // Give a stray extra result time to show up.
        repeat (8) @(negedge aclk);

        if (mismatch_count == 0) begin
            $display("** rv32im_instruction_decoder: PASSED **");
        end else begin
            $display("** rv32im_instruction_decoder: FAILED **");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/rv_dec_pkg.sv
rtl/rv_dec_core.sv
rtl/rv32im_instruction_decoder.sv
tb/sv/rv32im_instruction_decoder_test.sv
